>>> hdl/cfra_pkg.sv
// Package for the continued-fraction rational approximation block.
package cfra_pkg;
  localparam int unsigned FracBits = 32;
  localparam int unsigned ValW = 64;
  localparam int unsigned DenW = 34;
  localparam int unsigned TolW = 32;
  localparam int unsigned IterW = 10;
  localparam int unsigned CntW = 7;
  localparam int unsigned CfgAddrW = 1;
  localparam logic [IterW-1:0] IterReset = IterW'(1000);
  localparam logic [TolW-1:0] TolReset = TolW'(4);
  localparam logic [CfgAddrW-1:0] RegTol = 1'b0;
  localparam logic [CfgAddrW-1:0] RegIter = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic upd;
    logic mul_step;
    logic test;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic mul_last;
    logic hit;
    logic rem_zero;
  } sts_t;
endpackage

>>> hdl/cfra_datapath.sv
// Datapath: Euclid division, convergent update and exact error test.
module cfra_datapath (
  input  logic                          clk_i,
  input  cfra_pkg::cmd_t                cmd_i,
  input  logic [cfra_pkg::ValW-1:0]     value_i,
  input  logic [cfra_pkg::TolW-1:0]     tol_i,
  output cfra_pkg::sts_t                sts_o,
  output logic                          neg_o,
  output logic [cfra_pkg::ValW-1:0]     h_o,
  output logic [cfra_pkg::ValW-1:0]     k_o
);
  localparam int unsigned W = cfra_pkg::ValW;
  localparam int unsigned WW = 2 * W;
  localparam int unsigned CW = cfra_pkg::CntW;

  logic          neg_q;
  logic [W-1:0]  mag_q, num_q, den_q;
  logic [W-1:0]  quo_q, rem_q;
  logic [CW-1:0] dcnt_q;
  logic [W-1:0]  h1_q, h2_q, k1_q, k2_q, h_q, k_q;
  logic [W-1:0]  mh_q, mk_q, mm_q;
  logic [WW-1:0] ph_q, pk_q;
  logic [CW-1:0] mcnt_q;

  logic [W:0]    rtrial;
  logic [W-1:0]  rsh;

  always_comb begin
    rsh = {rem_q[W-2:0], quo_q[W-1]};
    rtrial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[W-1];
      mag_q <= value_i[W-1] ? W'(0) - value_i : value_i;
      num_q <= value_i[W-1] ? W'(0) - value_i : value_i;
      den_q <= W'(1) << cfra_pkg::FracBits;
      h1_q <= W'(1); h2_q <= '0; k1_q <= '0; k2_q <= W'(1);
    end
    if (cmd_i.div_start) begin
      quo_q <= num_q;
      rem_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + CW'(1);
      if (!rtrial[W]) begin
        rem_q <= rtrial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.upd) begin
      mh_q <= h1_q; mk_q <= k1_q; mm_q <= mag_q;
      ph_q <= {{W{1'b0}}, h2_q}; pk_q <= {{W{1'b0}}, k2_q};
      mcnt_q <= '0;
    end else if (cmd_i.mul_step) begin
      mcnt_q <= mcnt_q + CW'(1);
      if (quo_q[mcnt_q[CW-2:0]]) begin
        ph_q <= ph_q + ({{W{1'b0}}, mh_q} << mcnt_q[CW-2:0]);
        pk_q <= pk_q + ({{W{1'b0}}, mk_q} << mcnt_q[CW-2:0]);
      end
    end
    if (cmd_i.test) begin
      h_q <= ph_q[W-1:0];
      k_q <= pk_q[W-1:0];
    end
    if (cmd_i.advance) begin
      num_q <= den_q; den_q <= rem_q;
      h2_q <= h1_q; h1_q <= h_q;
      k2_q <= k1_q; k1_q <= k_q;
    end
  end

  // Product phase for the error test: mag*k and tol*k, serial over bits of k.
  logic          pbusy_q;
  logic [CW-1:0] pcnt_q;
  logic [WW-1:0] pacc_b_q, pacc_t_q;
  logic          pstep;
  logic [WW-1:0] ha_w, hd_w;

  always_comb begin
    pstep = cmd_i.mul_step && pbusy_q;
    ha_w = {{(W - cfra_pkg::FracBits){1'b0}}, h_q, {cfra_pkg::FracBits{1'b0}}};
    hd_w = (ha_w >= pacc_b_q) ? ha_w - pacc_b_q : pacc_b_q - ha_w;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.test) begin
      pcnt_q <= '0;
      pacc_b_q <= '0;
      pacc_t_q <= '0;
    end else if (pstep) begin
      pcnt_q <= pcnt_q + CW'(1);
      if (k_q[pcnt_q[CW-2:0]]) begin
        pacc_b_q <= pacc_b_q + ({{W{1'b0}}, mm_q} << pcnt_q[CW-2:0]);
        pacc_t_q <= pacc_t_q + ({{(WW-cfra_pkg::TolW){1'b0}}, tol_i} << pcnt_q[CW-2:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) pbusy_q <= 1'b0;
    else if (cmd_i.test) pbusy_q <= 1'b1;
  end

  always_comb begin
    sts_o.div_last = (dcnt_q == CW'(W - 1));
    sts_o.mul_last = pbusy_q ? (pcnt_q == CW'(W - 1)) : (mcnt_q == CW'(W - 1));
    sts_o.hit = (hd_w < pacc_t_q);
    sts_o.rem_zero = (rem_q == '0);
  end
  assign neg_o = neg_q;
  assign h_o = h_q;
  assign k_o = k_q;
endmodule

>>> hdl/cfra_ctrl.sv
// Controller: sequences division, convergent update and test per Euclid step.
module cfra_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  input  logic [cfra_pkg::IterW-1:0]     max_iter_i,
  input  cfra_pkg::sts_t                 sts_i,
  output cfra_pkg::cmd_t                 cmd_o,
  output logic                           hit_o,
  output logic                           odd_o
);
  typedef enum logic [7:0] {
    SIdle = 8'b00000001, SStart = 8'b00000010, SDiv = 8'b00000100,
    SUpd = 8'b00001000, SMul = 8'b00010000, STest = 8'b00100000,
    SProd = 8'b01000000, SDone = 8'b10000000
  } state_e;
  state_e state_q, state_d;
  logic [cfra_pkg::IterW-1:0] it_q, it_d;
  logic hit_q, hit_d;

  always_comb begin
    state_d = state_q; it_d = it_q; hit_d = hit_q;
    cmd_o = '0;
    in_ready_o = (state_q == SIdle);
    res_valid_o = (state_q == SDone);
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1; it_d = '0; hit_d = 1'b0;
        state_d = (max_iter_i == '0) ? SDone : SStart;
      end
      SStart: begin cmd_o.div_start = 1'b1; state_d = SDiv; end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = SUpd;
      end
      SUpd: begin cmd_o.upd = 1'b1; state_d = SMul; end
      SMul: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = STest;
      end
      STest: begin cmd_o.test = 1'b1; state_d = SProd; end
      SProd: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          if (sts_i.hit) begin hit_d = 1'b1; state_d = SDone; end
          else if (sts_i.rem_zero || (it_q + 10'd1 == max_iter_i)) state_d = SDone;
          else begin
            cmd_o.advance = 1'b1; it_d = it_q + 10'd1; state_d = SStart;
          end
        end
      end
      SDone: if (res_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; it_q <= '0; hit_q <= 1'b0;
    end else begin
      state_q <= state_d; it_q <= it_d; hit_q <= hit_d;
    end
  end
  assign hit_o = hit_q;
  assign odd_o = it_q[0];
endmodule

>>> hdl/continued_fraction_rational_approx.sv
// Top level of the continued-fraction rational approximation block.
// One value at a time: each Euclid step runs a restoring division, a shift-add
// convergent update and an exact error test, for up to max_iterations steps,
// followed by the result state. Result 0/0 means no match.
module continued_fraction_rational_approx (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [103:0]                   m_axis_tdata,  // numerator, denominator, pad
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cfra_pkg::CfgAddrW-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  logic [cfra_pkg::TolW-1:0]  tol_q;
  logic [cfra_pkg::IterW-1:0] iter_q;
  cfra_pkg::cmd_t cmd;
  cfra_pkg::sts_t sts;
  logic neg, hit, odd;
  logic [63:0] h, k, hn, kn;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= cfra_pkg::TolReset; iter_q <= cfra_pkg::IterReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cfra_pkg::RegTol: tol_q <= cfg_data_i;
        cfra_pkg::RegIter: iter_q <= cfg_data_i[cfra_pkg::IterW-1:0];
        default: ;
      endcase
    end
  end

  cfra_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .max_iter_i(iter_q),
    .sts_i(sts), .cmd_o(cmd), .hit_o(hit), .odd_o(odd)
  );
  cfra_datapath u_dp (
    .clk_i, .cmd_i(cmd), .value_i(s_axis_tdata), .tol_i(tol_q), .sts_o(sts),
    .neg_o(neg), .h_o(h), .k_o(k)
  );

  always_comb begin
    hn = (neg && !odd) ? 64'd0 - h : h;
    kn = (neg && odd) ? 64'd0 - k : k;
    if (!hit) begin hn = '0; kn = '0; end
    m_axis_tdata = {6'd0, kn[33:0], hn};
  end
endmodule
